@@ rtl/srgb_gray_pkg.sv @@
// ----------------------------------------------------------------------------
// srgb_gray_pkg
// Types, register codes and constant tables for sRGB luminance grayscale.
// ----------------------------------------------------------------------------
`default_nettype none
package srgb_gray_pkg;

  localparam int LINEAR_FRAC_BITS = 16;
  localparam int LIN_W = LINEAR_FRAC_BITS + 1;
  localparam int WEIGHT_W = 17;
  localparam int PROD_W = LIN_W + WEIGHT_W;
  localparam int SUM_W = PROD_W + 2;
  localparam int LUMA_W = SUM_W - 16;
  localparam int ADDR_W = 4;

  localparam logic [WEIGHT_W-1:0] RED_WEIGHT_RST = 17'd13933;
  localparam logic [WEIGHT_W-1:0] GREEN_WEIGHT_RST = 17'd46871;
  localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_RST = 17'd4732;

  localparam logic [1:0] REG_RED_WEIGHT = 2'd0;
  localparam logic [1:0] REG_GREEN_WEIGHT = 2'd1;
  localparam logic [1:0] REG_BLUE_WEIGHT = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] gray;
    logic       frame_end_out;
  } pixel_out_t;

  typedef logic [LIN_W-1:0] lin_tab_t [256];
  typedef logic [LIN_W-1:0] thr_tab_t [255];

  // Linear light of an sRGB code given in half-code steps, rounded.
  function automatic logic [LIN_W-1:0] linear_of_half(input int h);
    real x;
    real v;
    x = h / 510.0;
    if (h <= 20) begin
      v = x / 12.92;
    end else begin
      v = ((x + 0.055) / 1.055) ** 2.4;
    end
    return LIN_W'($rtoi(v * (2.0 ** LINEAR_FRAC_BITS) + 0.5));
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t t;
    for (int c = 0; c < 256; c++) begin
      t[c] = linear_of_half(2 * c);
    end
    return t;
  endfunction

  function automatic thr_tab_t build_thr();
    thr_tab_t t;
    for (int k = 1; k < 256; k++) begin
      t[k-1] = linear_of_half(2 * k - 1);
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();
  localparam thr_tab_t THR_TAB = build_thr();

endpackage
`default_nettype wire

@@ rtl/srgb_luminance_grayscale.sv @@
// ----------------------------------------------------------------------------
// srgb_luminance_grayscale
// Gamma-correct grayscale of one sRGB pixel per clock.
// ----------------------------------------------------------------------------
// The stages are input capture, table lookup and weighting, summing,
// threshold compare, and code search; the receiver cannot stall the results.
// One word is accepted every cycle, so busy is always low.
// The out_valid strobe comes out together with the code search result.
// Reset clears the valid pipeline and loads the Rec.709 weights.
// ----------------------------------------------------------------------------
`default_nettype none
module srgb_luminance_grayscale (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire srgb_gray_pkg::pixel_in_t          in_data,
  output logic                                   out_valid,
  output srgb_gray_pkg::pixel_out_t              out_data,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [srgb_gray_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import srgb_gray_pkg::*;

  logic [WEIGHT_W-1:0] red_w_r, green_w_r, blue_w_r;
  logic [4:0]          vld_r;
  pixel_in_t           in_r;
  logic [PROD_W-1:0]   pr_r, pg_r, pb_r;
  logic [LUMA_W-1:0]   luma_r;
  logic [254:0]        therm_r;
  logic [3:0]          fe_r;
  logic [7:0]          gray_r;
  logic [SUM_W-1:0]    sum_nxt;
  logic [254:0]        therm_nxt;
  logic [7:0]          gray_nxt;
  logic [7:0]          cand;

  assign busy = 1'b0;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_RED_WEIGHT:   prdata = {15'd0, red_w_r};
      REG_GREEN_WEIGHT: prdata = {15'd0, green_w_r};
      REG_BLUE_WEIGHT:  prdata = {15'd0, blue_w_r};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_w_r <= RED_WEIGHT_RST;
      green_w_r <= GREEN_WEIGHT_RST;
      blue_w_r <= BLUE_WEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_RED_WEIGHT:   red_w_r <= pwdata[WEIGHT_W-1:0];
        REG_GREEN_WEIGHT: green_w_r <= pwdata[WEIGHT_W-1:0];
        REG_BLUE_WEIGHT:  blue_w_r <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign sum_nxt = SUM_W'(pr_r) + SUM_W'(pg_r) + SUM_W'(pb_r);

  always_comb begin
    for (int k = 0; k < 255; k++) begin
      therm_nxt[k] = LUMA_W'(THR_TAB[k]) <= luma_r;
    end
  end

  // The thermometer is monotone, so the count is found by binary search.
  always_comb begin
    gray_nxt = 8'd0;
    cand = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      cand = gray_nxt | (8'd1 << b);
      if (therm_r[cand - 8'd1]) begin
        gray_nxt = cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
    pr_r <= PROD_W'(red_w_r) * PROD_W'(LIN_TAB[in_r.red]);
    pg_r <= PROD_W'(green_w_r) * PROD_W'(LIN_TAB[in_r.green]);
    pb_r <= PROD_W'(blue_w_r) * PROD_W'(LIN_TAB[in_r.blue]);
    luma_r <= sum_nxt[SUM_W-1:16];
    therm_r <= therm_nxt;
    gray_r <= gray_nxt;
    fe_r <= {fe_r[2:0], in_r.frame_end_in};
  end

  assign out_valid = vld_r[4];
  assign out_data.gray = gray_r;
  assign out_data.frame_end_out = fe_r[3];

endmodule
`default_nettype wire
